// File: rtl/core/v3a_pkg.sv
package v3a_pkg;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_DOT   = 4'd4;
    localparam logic [3:0] OP_CROSS = 4'd5;
    localparam logic [3:0] OP_LEN   = 4'd6;
    localparam logic [3:0] OP_DIST  = 4'd7;
    localparam logic [3:0] OP_NORM  = 4'd8;

    // one result bit per square-root step
    localparam int SQRT_STEPS = 32;

    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } sat_t;

    // state leaving the multiply/add front end
    typedef struct packed {
        logic [3:0]       op;
        logic [2:0][31:0] r;
        logic [31:0]      sc;
        logic             ovf;
        logic             len_ovf;
        logic [63:0]      sq_sum;
        logic [2:0]       a_neg;
        logic [2:0][31:0] a_mag;
        logic [2:0]       b_neg;
        logic [2:0][31:0] b_mag;
        logic [2:0]       b_zero;
    } front_t;

    function automatic sat_t sat66(input logic signed [65:0] v);
        sat_t s;
        if (v[65:31] == {35{v[65]}}) begin
            s.val = v[31:0];
            s.ovf = 1'b0;
        end else begin
            s.val = v[65] ? WORD_MIN : WORD_MAX;
            s.ovf = 1'b1;
        end
        return s;
    endfunction

endpackage

// File: rtl/core/v3a_front.sv
module v3a_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_vld,
    input  logic [3:0]        in_op,
    input  logic [2:0][31:0]  in_a,
    input  logic [2:0][31:0]  in_b,
    output logic              out_vld,
    output v3a_pkg::front_t   out_pay
);

    // stage 1: captured operands
    logic             s1_vld_reg;
    logic [3:0]       s1_op_reg;
    logic [2:0][31:0] s1_a_reg;
    logic [2:0][31:0] s1_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_op_reg <= in_op;
            s1_a_reg  <= in_a;
            s1_b_reg  <= in_b;
        end
    end

    // stage 2: add/sub, magnitudes, multiplier operand select
    logic signed [32:0] a_ext [3];
    logic signed [32:0] b_ext [3];
    logic signed [32:0] add_w [3];
    logic signed [32:0] d_w   [3];
    logic signed [32:0] d_mag [3];
    logic [2:0]         d_big;
    v3a_pkg::sat_t      add_sat [3];
    logic signed [32:0] ml_next [6];
    logic signed [32:0] mr_next [6];
    logic [2:0][31:0]   a_mag_next;
    logic [2:0][31:0]   b_mag_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_ext[i] = {s1_a_reg[i][31], s1_a_reg[i]};
            b_ext[i] = {s1_b_reg[i][31], s1_b_reg[i]};
            add_w[i] = (s1_op_reg == v3a_pkg::OP_SUB) ? a_ext[i] - b_ext[i]
                                                      : a_ext[i] + b_ext[i];
            add_sat[i] = v3a_pkg::sat66({{33{add_w[i][32]}}, add_w[i]});
            d_w[i]   = b_ext[i] - a_ext[i];
            d_mag[i] = d_w[i][32] ? -d_w[i] : d_w[i];
            d_big[i] = d_mag[i][32] | d_mag[i][31];
            a_mag_next[i] = s1_a_reg[i][31] ? ~s1_a_reg[i] + 32'd1 : s1_a_reg[i];
            b_mag_next[i] = s1_b_reg[i][31] ? ~s1_b_reg[i] + 32'd1 : s1_b_reg[i];
        end
        for (int j = 0; j < 6; j++) begin
            ml_next[j] = '0;
            mr_next[j] = '0;
        end
        unique case (s1_op_reg)
            v3a_pkg::OP_MUL, v3a_pkg::OP_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    ml_next[i] = a_ext[i];
                    mr_next[i] = b_ext[i];
                end
            end
            v3a_pkg::OP_CROSS: begin
                ml_next[0] = a_ext[1]; mr_next[0] = b_ext[2];
                ml_next[1] = a_ext[2]; mr_next[1] = b_ext[1];
                ml_next[2] = a_ext[2]; mr_next[2] = b_ext[0];
                ml_next[3] = a_ext[0]; mr_next[3] = b_ext[2];
                ml_next[4] = a_ext[0]; mr_next[4] = b_ext[1];
                ml_next[5] = a_ext[1]; mr_next[5] = b_ext[0];
            end
            v3a_pkg::OP_LEN, v3a_pkg::OP_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    ml_next[i] = {1'b0, a_mag_next[i]};
                    mr_next[i] = {1'b0, a_mag_next[i]};
                end
            end
            v3a_pkg::OP_DIST: begin
                // a too-large difference saturates anyway; square zero instead
                for (int i = 0; i < 3; i++) begin
                    ml_next[i] = d_big[i] ? '0 : d_mag[i];
                    mr_next[i] = d_big[i] ? '0 : d_mag[i];
                end
            end
            default: begin
            end
        endcase
    end

    logic               s2_vld_reg;
    logic [3:0]         s2_op_reg;
    logic signed [32:0] s2_ml_reg [6];
    logic signed [32:0] s2_mr_reg [6];
    logic [2:0][31:0]   s2_add_reg;
    logic [2:0]         s2_add_ovf_reg;
    logic               s2_len_ovf_reg;
    logic [2:0]         s2_a_neg_reg;
    logic [2:0][31:0]   s2_a_mag_reg;
    logic [2:0]         s2_b_neg_reg;
    logic [2:0][31:0]   s2_b_mag_reg;
    logic [2:0]         s2_b_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (adv) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_op_reg      <= s1_op_reg;
            s2_ml_reg      <= ml_next;
            s2_mr_reg      <= mr_next;
            s2_len_ovf_reg <= (s1_op_reg == v3a_pkg::OP_DIST) && (|d_big);
            s2_a_mag_reg   <= a_mag_next;
            s2_b_mag_reg   <= b_mag_next;
            for (int i = 0; i < 3; i++) begin
                s2_add_reg[i]     <= add_sat[i].val;
                s2_add_ovf_reg[i] <= add_sat[i].ovf;
                s2_a_neg_reg[i]   <= s1_a_reg[i][31];
                s2_b_neg_reg[i]   <= s1_b_reg[i][31];
                s2_b_zero_reg[i]  <= (s1_b_reg[i] == 32'd0);
            end
        end
    end

    // stage 3: six products
    logic signed [65:0] prod_w [6];

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            prod_w[j] = s2_ml_reg[j] * s2_mr_reg[j];
        end
    end

    logic               s3_vld_reg;
    logic [3:0]         s3_op_reg;
    logic signed [63:0] s3_p_reg [6];
    logic [2:0][31:0]   s3_add_reg;
    logic [2:0]         s3_add_ovf_reg;
    logic               s3_len_ovf_reg;
    logic [2:0]         s3_a_neg_reg;
    logic [2:0][31:0]   s3_a_mag_reg;
    logic [2:0]         s3_b_neg_reg;
    logic [2:0][31:0]   s3_b_mag_reg;
    logic [2:0]         s3_b_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (adv) begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_op_reg      <= s2_op_reg;
            for (int j = 0; j < 6; j++) begin
                s3_p_reg[j] <= prod_w[j][63:0];
            end
            s3_add_reg     <= s2_add_reg;
            s3_add_ovf_reg <= s2_add_ovf_reg;
            s3_len_ovf_reg <= s2_len_ovf_reg;
            s3_a_neg_reg   <= s2_a_neg_reg;
            s3_a_mag_reg   <= s2_a_mag_reg;
            s3_b_neg_reg   <= s2_b_neg_reg;
            s3_b_mag_reg   <= s2_b_mag_reg;
            s3_b_zero_reg  <= s2_b_zero_reg;
        end
    end

    // stage 4: exact sums and differences of products
    logic signed [65:0] pe    [6];
    logic signed [65:0] t_next [3];

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            pe[j] = {{2{s3_p_reg[j][63]}}, s3_p_reg[j]};
        end
        for (int i = 0; i < 3; i++) begin
            t_next[i] = '0;
        end
        unique case (s3_op_reg)
            v3a_pkg::OP_MUL: begin
                t_next[0] = pe[0];
                t_next[1] = pe[1];
                t_next[2] = pe[2];
            end
            v3a_pkg::OP_CROSS: begin
                t_next[0] = pe[0] - pe[1];
                t_next[1] = pe[2] - pe[3];
                t_next[2] = pe[4] - pe[5];
            end
            v3a_pkg::OP_DOT, v3a_pkg::OP_LEN, v3a_pkg::OP_DIST, v3a_pkg::OP_NORM: begin
                t_next[0] = pe[0] + pe[1] + pe[2];
            end
            default: begin
            end
        endcase
    end

    logic               s4_vld_reg;
    logic [3:0]         s4_op_reg;
    logic signed [65:0] s4_t_reg [3];
    logic [2:0][31:0]   s4_add_reg;
    logic [2:0]         s4_add_ovf_reg;
    logic               s4_len_ovf_reg;
    logic [2:0]         s4_a_neg_reg;
    logic [2:0][31:0]   s4_a_mag_reg;
    logic [2:0]         s4_b_neg_reg;
    logic [2:0][31:0]   s4_b_mag_reg;
    logic [2:0]         s4_b_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
        end else if (adv) begin
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_op_reg      <= s3_op_reg;
            s4_t_reg       <= t_next;
            s4_add_reg     <= s3_add_reg;
            s4_add_ovf_reg <= s3_add_ovf_reg;
            s4_len_ovf_reg <= s3_len_ovf_reg;
            s4_a_neg_reg   <= s3_a_neg_reg;
            s4_a_mag_reg   <= s3_a_mag_reg;
            s4_b_neg_reg   <= s3_b_neg_reg;
            s4_b_mag_reg   <= s3_b_mag_reg;
            s4_b_zero_reg  <= s3_b_zero_reg;
        end
    end

    // stage 5: floor shift and saturate
    v3a_pkg::sat_t   fsat [3];
    v3a_pkg::front_t pay_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fsat[i] = v3a_pkg::sat66(s4_t_reg[i] >>> FRAC_BITS);
        end
        pay_next.op      = s4_op_reg;
        pay_next.r       = '0;
        pay_next.sc      = '0;
        pay_next.ovf     = 1'b0;
        pay_next.len_ovf = s4_len_ovf_reg;
        pay_next.sq_sum  = s4_t_reg[0][63:0];
        pay_next.a_neg   = s4_a_neg_reg;
        pay_next.a_mag   = s4_a_mag_reg;
        pay_next.b_neg   = s4_b_neg_reg;
        pay_next.b_mag   = s4_b_mag_reg;
        pay_next.b_zero  = s4_b_zero_reg;
        unique case (s4_op_reg)
            v3a_pkg::OP_ADD, v3a_pkg::OP_SUB: begin
                pay_next.r   = s4_add_reg;
                pay_next.ovf = |s4_add_ovf_reg;
            end
            v3a_pkg::OP_MUL, v3a_pkg::OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    pay_next.r[i] = fsat[i].val;
                end
                pay_next.ovf = fsat[0].ovf | fsat[1].ovf | fsat[2].ovf;
            end
            v3a_pkg::OP_DOT: begin
                pay_next.sc  = fsat[0].val;
                pay_next.ovf = fsat[0].ovf;
            end
            default: begin
            end
        endcase
    end

    logic            s5_vld_reg;
    v3a_pkg::front_t s5_pay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_vld_reg <= 1'b0;
        end else if (adv) begin
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_pay_reg <= pay_next;
        end
    end

    assign out_vld = s5_vld_reg;
    assign out_pay = s5_pay_reg;

endmodule

// File: rtl/core/v3a_sqrt.sv
module v3a_sqrt (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_vld,
    input  v3a_pkg::front_t in_pay,
    output logic            out_vld,
    output v3a_pkg::front_t out_pay,
    output logic [31:0]     out_root
);

    localparam int N = v3a_pkg::SQRT_STEPS;

    logic            vld_reg  [N];
    logic [32:0]     rem_reg  [N];
    logic [31:0]     root_reg [N];
    logic [63:0]     src_reg  [N];
    v3a_pkg::front_t pay_reg  [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic            p_vld;
        logic [32:0]     p_rem;
        logic [31:0]     p_root;
        logic [63:0]     p_src;
        v3a_pkg::front_t p_pay;
        logic [34:0]     sh;
        logic [34:0]     trial;
        logic [34:0]     diff;
        logic            fits;

        if (k == 0) begin : g_head
            assign p_vld  = in_vld;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_src  = in_pay.sq_sum;
            assign p_pay  = in_pay;
        end else begin : g_link
            assign p_vld  = vld_reg[k-1];
            assign p_rem  = rem_reg[k-1];
            assign p_root = root_reg[k-1];
            assign p_src  = src_reg[k-1];
            assign p_pay  = pay_reg[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign sh    = {p_rem, p_src[63:62]};
        assign trial = {1'b0, p_root, 2'b01};
        assign diff  = sh - trial;
        assign fits  = (sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= p_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k]  <= fits ? diff[32:0] : sh[32:0];
                root_reg[k] <= {p_root[30:0], fits};
                src_reg[k]  <= {p_src[61:0], 2'b00};
                pay_reg[k]  <= p_pay;
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_pay  = pay_reg[N-1];
    assign out_root = root_reg[N-1];

endmodule

// File: rtl/core/v3a_div.sv
module v3a_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  logic                    in_vld,
    input  v3a_pkg::front_t         in_pay,
    input  logic [31:0]             in_root,
    output logic                    out_vld,
    output v3a_pkg::front_t         out_pay,
    output logic [31:0]             out_root,
    output logic [2:0][FRAC_BITS+31:0] out_quo
);

    localparam int DW = 32 + FRAC_BITS;

    logic                vld_reg  [DW];
    v3a_pkg::front_t     pay_reg  [DW];
    logic [31:0]         root_reg [DW];
    logic [2:0][31:0]    den_reg  [DW];
    logic [2:0][31:0]    rem_reg  [DW];
    logic [2:0][DW-1:0]  nq_reg   [DW];

    for (genvar k = 0; k < DW; k++) begin : g_step
        logic               p_vld;
        v3a_pkg::front_t    p_pay;
        logic [31:0]        p_root;
        logic [2:0][31:0]   p_den;
        logic [2:0][31:0]   p_rem;
        logic [2:0][DW-1:0] p_nq;
        logic [2:0][31:0]   rem_next;
        logic [2:0][DW-1:0] nq_next;
        logic [32:0]        sh   [3];
        logic [33:0]        diff [3];

        if (k == 0) begin : g_head
            always_comb begin
                p_vld  = in_vld;
                p_pay  = in_pay;
                p_root = in_root;
                p_rem  = '0;
                for (int i = 0; i < 3; i++) begin
                    p_nq[i]  = {in_pay.a_mag[i], {FRAC_BITS{1'b0}}};
                    p_den[i] = (in_pay.op == v3a_pkg::OP_NORM) ? in_root
                                                                : in_pay.b_mag[i];
                end
            end
        end else begin : g_link
            assign p_vld  = vld_reg[k-1];
            assign p_pay  = pay_reg[k-1];
            assign p_root = root_reg[k-1];
            assign p_den  = den_reg[k-1];
            assign p_rem  = rem_reg[k-1];
            assign p_nq   = nq_reg[k-1];
        end

        // restoring step: shift in next dividend bit, subtract if it fits
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                sh[i]   = {p_rem[i], p_nq[i][DW-1]};
                diff[i] = {1'b0, sh[i]} - {2'b00, p_den[i]};
                rem_next[i] = diff[i][33] ? sh[i][31:0] : diff[i][31:0];
                nq_next[i]  = {p_nq[i][DW-2:0], ~diff[i][33]};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= p_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                pay_reg[k]  <= p_pay;
                root_reg[k] <= p_root;
                den_reg[k]  <= p_den;
                rem_reg[k]  <= rem_next;
                nq_reg[k]   <= nq_next;
            end
        end
    end

    assign out_vld  = vld_reg[DW-1];
    assign out_pay  = pay_reg[DW-1];
    assign out_root = root_reg[DW-1];
    assign out_quo  = nq_reg[DW-1];

endmodule

// File: rtl/core/vector3_alu.sv
// Channel  Ports                                 Fields (lowest bit up)
// input    s_tvalid s_tready s_tdata s_tuser     tuser: operation; tdata: ax ay az bx by bz
// result   m_tvalid m_tready m_tdata m_tuser     tdata: rx ry rz scalar_out;
//                                                tuser: overflow divide_by_zero
//
// One transfer per cycle in each direction while the output is not stalled; the pipeline is
// five multiply/add stages, 32 square-root stages (one root bit each),
// 32 + FRAC_BITS divider stages (one quotient bit each, three lanes), one output stage.
// Reset clears the valid bits of all stages and of the output register.
// While a result sits unaccepted the whole pipeline holds and s_tready is low.
module vector3_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // ax, ay, az, bx, by, bz
    input  logic [3:0]   s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // rx, ry, rz, scalar_out
    output logic [1:0]   m_tuser    // overflow, divide_by_zero
);

    localparam int DW = 32 + FRAC_BITS;

    logic adv;
    logic m_tvalid_reg;

    // advance every stage whenever the output register is free or drained
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    logic [2:0][31:0] in_a;
    logic [2:0][31:0] in_b;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_a[i] = s_tdata[32*i +: 32];
            in_b[i] = s_tdata[96 + 32*i +: 32];
        end
    end

    logic            fr_vld;
    v3a_pkg::front_t fr_pay;

    v3a_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (s_tvalid && adv),
        .in_op   (s_tuser),
        .in_a    (in_a),
        .in_b    (in_b),
        .out_vld (fr_vld),
        .out_pay (fr_pay)
    );

    logic            sq_vld;
    v3a_pkg::front_t sq_pay;
    logic [31:0]     sq_root;

    v3a_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_vld   (fr_vld),
        .in_pay   (fr_pay),
        .out_vld  (sq_vld),
        .out_pay  (sq_pay),
        .out_root (sq_root)
    );

    logic               dv_vld;
    v3a_pkg::front_t    dv_pay;
    logic [31:0]        dv_root;
    logic [2:0][DW-1:0] dv_quo;

    v3a_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_vld   (sq_vld),
        .in_pay   (sq_pay),
        .in_root  (sq_root),
        .out_vld  (dv_vld),
        .out_pay  (dv_pay),
        .out_root (dv_root),
        .out_quo  (dv_quo)
    );

    // signed, saturated quotients
    logic [2:0][31:0] q_val;
    logic [2:0]       q_ovf;
    logic [2:0]       q_neg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q_neg[i] = dv_pay.a_neg[i] ^ ((dv_pay.op == v3a_pkg::OP_DIV) & dv_pay.b_neg[i]);
            if (q_neg[i]) begin
                if ((|dv_quo[i][DW-1:32]) || (dv_quo[i][31] && (|dv_quo[i][30:0]))) begin
                    q_val[i] = v3a_pkg::WORD_MIN;
                    q_ovf[i] = 1'b1;
                end else begin
                    q_val[i] = ~dv_quo[i][31:0] + 32'd1;
                    q_ovf[i] = 1'b0;
                end
            end else begin
                if (|dv_quo[i][DW-1:31]) begin
                    q_val[i] = v3a_pkg::WORD_MAX;
                    q_ovf[i] = 1'b1;
                end else begin
                    q_val[i] = dv_quo[i][31:0];
                    q_ovf[i] = 1'b0;
                end
            end
        end
    end

    logic [2:0][31:0] r_next;
    logic [31:0]      sc_next;
    logic             ovf_next;
    logic             dz_next;

    always_comb begin
        r_next   = '0;
        sc_next  = '0;
        ovf_next = 1'b0;
        dz_next  = 1'b0;
        unique case (dv_pay.op)
            v3a_pkg::OP_ADD, v3a_pkg::OP_SUB, v3a_pkg::OP_MUL,
            v3a_pkg::OP_DOT, v3a_pkg::OP_CROSS: begin
                r_next   = dv_pay.r;
                sc_next  = dv_pay.sc;
                ovf_next = dv_pay.ovf;
            end
            v3a_pkg::OP_LEN, v3a_pkg::OP_DIST: begin
                if (dv_pay.len_ovf || dv_root[31]) begin
                    sc_next  = v3a_pkg::WORD_MAX;
                    ovf_next = 1'b1;
                end else begin
                    sc_next = dv_root;
                end
            end
            v3a_pkg::OP_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    if (dv_pay.b_zero[i]) begin
                        r_next[i] = dv_pay.a_neg[i] ? v3a_pkg::WORD_MIN : v3a_pkg::WORD_MAX;
                        dz_next   = 1'b1;
                    end else begin
                        r_next[i] = q_val[i];
                        ovf_next  = ovf_next | q_ovf[i];
                    end
                end
            end
            v3a_pkg::OP_NORM: begin
                // zero vector normalizes to zero
                if (dv_root != 32'd0) begin
                    r_next   = q_val;
                    ovf_next = |q_ovf;
                end
            end
            default: begin
            end
        endcase
    end

    logic [127:0] m_tdata_reg;
    logic [1:0]   m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= dv_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= {sc_next, r_next[2], r_next[1], r_next[0]};
            m_tuser_reg <= {dz_next, ovf_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_scalar_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[127:96] != 32'd0) |-> (m_tdata[95:0] == 96'd0))
        else $error("scalar and vector results both nonzero");

    a_dz_scalar: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata[127:96] == 32'd0))
        else $error("divide-by-zero flag on a scalar result");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

// File: sim/vec3_checker.sv
module vec3_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [191:0] s_tdata,   // ax, ay, az, bx, by, bz
    input  logic [3:0]   s_tuser,   // operation
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,   // rx, ry, rz, scalar_out
    input  logic [1:0]   m_tuser,   // overflow, divide_by_zero
    output int           fail_count,
    output int           pending
);

    localparam int FRAC = 16;
    localparam longint LMAX = 64'sd2147483647;
    localparam longint LMIN = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] rx, ry, rz, sc;
        logic               ovf, dz;
    } vres_t;

    vres_t expected_q[$];

    function automatic logic signed [31:0] sat_word(input logic signed [71:0] v,
                                                    inout logic ovf);
        if (v > LMAX) begin
            ovf = 1'b1;
            return LMAX[31:0];
        end
        if (v < LMIN) begin
            ovf = 1'b1;
            return LMIN[31:0];
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] s);
        logic [127:0] res;
        logic [127:0] cand;
        res = '0;
        for (int i = 32; i >= 0; i--) begin
            cand = res | (128'd1 << i);
            if (cand * cand <= {64'd0, s})
                res = cand;
        end
        return res[63:0];
    endfunction

    // floor length of a vector with 33-bit components, clamped
    function automatic logic signed [31:0] vec_len(input logic signed [71:0] d[3],
                                                   inout logic ovf);
        logic [63:0] s;
        logic [71:0] m;
        logic [63:0] r;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            m = d[i] < 0 ? -d[i] : d[i];
            if (m >= 72'd2147483648) begin
                ovf = 1'b1;
                return LMAX[31:0];
            end
            s += m[63:0] * m[63:0];
        end
        r = root_floor(s);
        if (r > 64'd2147483647) begin
            ovf = 1'b1;
            return LMAX[31:0];
        end
        return r[31:0];
    endfunction

    function automatic vres_t compute_vec(input logic [3:0] op, input logic [191:0] d);
        vres_t o;
        logic signed [71:0] a[3], b[3], t[3], acc;
        logic signed [31:0] r[3];
        logic [63:0] s, len;
        logic [71:0] m;
        logic ovf, dz;
        ovf = 0;
        dz = 0;
        r = '{default: 0};
        o.sc = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = $signed(d[32*i +: 32]);
            b[i] = $signed(d[96 + 32*i +: 32]);
        end
        case (op)
            v3a_pkg::OP_ADD:
                for (int i = 0; i < 3; i++) r[i] = sat_word(a[i] + b[i], ovf);
            v3a_pkg::OP_SUB:
                for (int i = 0; i < 3; i++) r[i] = sat_word(a[i] - b[i], ovf);
            v3a_pkg::OP_MUL:
                for (int i = 0; i < 3; i++) r[i] = sat_word((a[i] * b[i]) >>> FRAC, ovf);
            v3a_pkg::OP_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    if (b[i] == 0) begin
                        dz = 1'b1;
                        r[i] = a[i] < 0 ? LMIN[31:0] : LMAX[31:0];
                    end else begin
                        r[i] = sat_word((a[i] <<< FRAC) / b[i], ovf);
                    end
                end
            end
            v3a_pkg::OP_DOT: begin
                acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
                o.sc = sat_word(acc >>> FRAC, ovf);
            end
            v3a_pkg::OP_CROSS: begin
                r[0] = sat_word((a[1] * b[2] - a[2] * b[1]) >>> FRAC, ovf);
                r[1] = sat_word((a[2] * b[0] - a[0] * b[2]) >>> FRAC, ovf);
                r[2] = sat_word((a[0] * b[1] - a[1] * b[0]) >>> FRAC, ovf);
            end
            v3a_pkg::OP_LEN: o.sc = vec_len(a, ovf);
            v3a_pkg::OP_DIST: begin
                for (int i = 0; i < 3; i++) t[i] = b[i] - a[i];
                o.sc = vec_len(t, ovf);
            end
            v3a_pkg::OP_NORM: begin
                s = '0;
                for (int i = 0; i < 3; i++) begin
                    m = a[i] < 0 ? -a[i] : a[i];
                    s += m[63:0] * m[63:0];
                end
                len = root_floor(s);
                // zero vector stays zero without a flag
                if (len != 0)
                    for (int i = 0; i < 3; i++)
                        r[i] = sat_word((a[i] <<< FRAC) / $signed({8'd0, len}), ovf);
            end
            default: ;
        endcase
        o.rx = r[0];
        o.ry = r[1];
        o.rz = r[2];
        o.ovf = ovf;
        o.dz = dz;
        return o;
    endfunction

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        vres_t e;
        vres_t got;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_q.push_back(compute_vec(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                got.rx = m_tdata[31:0];
                got.ry = m_tdata[63:32];
                got.rz = m_tdata[95:64];
                got.sc = m_tdata[127:96];
                got.ovf = m_tuser[0];
                got.dz = m_tuser[1];
                if (expected_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result transfer: r=%h %h %h sc=%h", got.rx,
                                 got.ry, got.rz, got.sc);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (got != e) begin
                        if (fail_count < 10)
                            $display({"mismatch: exp r=%h %h %h sc=%h ovf=%b dz=%b, ",
                                      "got r=%h %h %h sc=%h ovf=%b dz=%b"},
                                     e.rx, e.ry, e.rz, e.sc, e.ovf, e.dz,
                                     got.rx, got.ry, got.rz, got.sc, got.ovf, got.dz);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: sim/tb_top.sv
module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LATENCY = 86;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic [3:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    int           fail_count;
    int           pending;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           idle_cycles;

    vector3_alu u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    vec3_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // receiver backpressure
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(32'h0002_0000) - 32'h0001_0000;
            2: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
            3: begin
                case ($urandom_range(5))
                    0: return 32'h0000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h8000_0000;
                    3: return 32'h0001_0000;
                    4: return 32'hFFFF_FFFF;
                    default: return 32'hFFFF_0000;
                endcase
            end
            default: return $urandom_range(32'h2000_0000) - 32'h1000_0000;
        endcase
    endfunction

    task automatic send_vec(input logic [3:0] op, input logic [31:0] ax, ay, az,
                            input logic [31:0] bx, by, bz);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {bz, by, bx, az, ay, ax};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random();
        logic [3:0]  op;
        logic [31:0] b;
        op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9))
                                       : 4'($urandom_range(v3a_pkg::OP_NORM));
        case ($urandom_range(3))
            0: begin
                // scalar operand form
                b = pick_word();
                send_vec(op, pick_word(), pick_word(), pick_word(), b, b, b);
            end
            1: send_vec(op, pick_word(), pick_word(), pick_word(),
                        ($urandom_range(3) == 0) ? 32'd0 : pick_word(),
                        ($urandom_range(3) == 0) ? 32'd0 : pick_word(),
                        pick_word());
            default: send_vec(op, pick_word(), pick_word(), pick_word(),
                              pick_word(), pick_word(), pick_word());
        endcase
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        idle_cycles = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int op = v3a_pkg::OP_ADD; op <= v3a_pkg::OP_NORM; op++) begin
            send_vec(4'(op), 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_8000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFE_0000);
            send_vec(4'(op), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        end
        // divide by zero with positive, negative and zero dividends
        send_vec(v3a_pkg::OP_DIV, 32'h0003_0000, 32'hFFFD_0000, 32'd0, 32'd0, 32'd0, 32'd0);
        send_vec(v3a_pkg::OP_DIV, 32'h8000_0000, 32'h0001_0000, 32'h7FFF_FFFF,
                 32'hFFFF_FFFF, 32'd1, 32'd2);
        send_vec(v3a_pkg::OP_NORM, 32'd0, 32'd0, 32'd0, 32'd5, 32'd6, 32'd7);
        send_vec(v3a_pkg::OP_NORM, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_vec(v3a_pkg::OP_LEN, 32'h0003_0000, 32'h0004_0000, 32'd0, 32'd0, 32'd0, 32'd0);
        send_vec(v3a_pkg::OP_DIST, 32'h8000_0000, 32'd0, 32'd0, 32'h0000_0001, 32'd0, 32'd0);
        send_vec(4'hF, 32'h1234_5678, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                3: begin send_idle_pct = 14; recv_stall_pct = 14; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 185; n++)
                send_random();
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/v3a_pkg.sv
rtl/core/v3a_front.sv
rtl/core/v3a_sqrt.sv
rtl/core/v3a_div.sv
rtl/core/vector3_alu.sv
sim/vec3_checker.sv
sim/tb_top.sv
